// File: design/dtg_pkg.sv
package dtg_pkg;

    localparam int unsigned PHASE_MODULUS   = 8000;
    localparam int unsigned COS_TABLE_DEPTH = 2000;
    localparam int unsigned PHASE_W         = 13;
    localparam int unsigned WEIGHT_W        = 17;
    localparam int unsigned CFG_INDEX_W     = 2;

    // The table address is phase >> ADDR_SHIFT, as PHASE_MODULUS is four times COS_TABLE_DEPTH.
    localparam int unsigned ADDR_SHIFT  = 2;
    localparam int unsigned QUARTER_MAX = COS_TABLE_DEPTH / 4;
    localparam int unsigned QIDX_W      = 9;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd32768;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_WEIGHT = 2'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LOAD = 2'd1;
    localparam logic [1:0] STATUS_BAD_KEY  = 2'd2;

    // Input command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Row frequencies first, then column frequencies.
    localparam logic [PHASE_W-1:0] TONE_FREQ [8] = '{
        13'd697, 13'd770, 13'd852, 13'd941, 13'd1209, 13'd1336, 13'd1477, 13'd1633
    };

    localparam longint unsigned TAYLOR_DIV [7] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182
    };

    typedef logic signed [15:0] cos_table_t [QUARTER_MAX + 1];

    typedef struct packed {
        logic       known;
        logic [1:0] row;
        logic [1:0] col;
    } key_map_t;

    // One classified request passed from the front part to the back part.
    typedef struct packed {
        logic                tone_on;
        logic                mix;
        logic [1:0]          status;
        logic [PHASE_W-1:0]  row_phase;
        logic [PHASE_W-1:0]  col_phase;
        logic signed [15:0]  noise;
    } job_t;

    function automatic key_map_t key_decode(input logic [7:0] key);
        key_map_t m;
        m = '{known: 1'b1, row: 2'd0, col: 2'd0};
        unique case (key)
            "1": begin m.row = 2'd0; m.col = 2'd0; end
            "2": begin m.row = 2'd0; m.col = 2'd1; end
            "3": begin m.row = 2'd0; m.col = 2'd2; end
            "A": begin m.row = 2'd0; m.col = 2'd3; end
            "4": begin m.row = 2'd1; m.col = 2'd0; end
            "5": begin m.row = 2'd1; m.col = 2'd1; end
            "6": begin m.row = 2'd1; m.col = 2'd2; end
            "B": begin m.row = 2'd1; m.col = 2'd3; end
            "7": begin m.row = 2'd2; m.col = 2'd0; end
            "8": begin m.row = 2'd2; m.col = 2'd1; end
            "9": begin m.row = 2'd2; m.col = 2'd2; end
            "C": begin m.row = 2'd2; m.col = 2'd3; end
            "*": begin m.row = 2'd3; m.col = 2'd0; end
            "0": begin m.row = 2'd3; m.col = 2'd1; end
            "#": begin m.row = 2'd3; m.col = 2'd2; end
            "D": begin m.row = 2'd3; m.col = 2'd3; end
            default: m.known = 1'b0;
        endcase
        return m;
    endfunction

    // Quarter-wave cosine in Q15, from a truncating Q30 Taylor series.
    function automatic logic signed [15:0] quarter_cos(input longint unsigned n);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = HALF_PI_Q30 * n / COS_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = longint'(ONE_Q30);
        sum  = ONE_Q30;
        for (int k = 0; k < 7; k++) begin
            term = term * x2 / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        return 16'((sum * 32767 + ONE_Q30 / 2) / ONE_Q30);
    endfunction

    // Entry j holds the quarter wave at n = 4*j, the only points that table addresses reach.
    function automatic cos_table_t build_cos_table();
        cos_table_t t;
        for (int j = 0; j <= int'(QUARTER_MAX); j++)
            t[j] = quarter_cos(longint'(j) * 4);
        return t;
    endfunction

endpackage

// File: design/dtg_cos_rom.sv
module dtg_cos_rom (
    input  logic                             clk,
    input  logic [dtg_pkg::PHASE_W-1:0]      addr_a,
    input  logic [dtg_pkg::PHASE_W-1:0]      addr_b,
    output logic signed [15:0]               data_a,
    output logic signed [15:0]               data_b
);

    localparam int unsigned FOLD_W = dtg_pkg::PHASE_W - dtg_pkg::ADDR_SHIFT;

    localparam logic [FOLD_W-1:0] EDGE_1 = FOLD_W'(dtg_pkg::QUARTER_MAX);
    localparam logic [FOLD_W-1:0] EDGE_2 = FOLD_W'(2 * dtg_pkg::QUARTER_MAX);
    localparam logic [FOLD_W-1:0] EDGE_3 = FOLD_W'(3 * dtg_pkg::QUARTER_MAX);
    localparam logic [FOLD_W-1:0] EDGE_4 = FOLD_W'(4 * dtg_pkg::QUARTER_MAX);

    localparam dtg_pkg::cos_table_t COS_TABLE = dtg_pkg::build_cos_table();

    logic [dtg_pkg::QIDX_W-1:0] idx_a;
    logic [dtg_pkg::QIDX_W-1:0] idx_b;
    logic                       neg_a;
    logic                       neg_b;
    logic signed [15:0]         data_a_reg;
    logic signed [15:0]         data_b_reg;
    logic                       neg_a_reg;
    logic                       neg_b_reg;

    // Cosine mirrors about each quarter turn, so one quarter wave plus a sign covers a period.
    function automatic logic [dtg_pkg::QIDX_W:0] fold(input logic [dtg_pkg::PHASE_W-1:0] phase);
        logic [FOLD_W-1:0] a;
        logic [FOLD_W-1:0] i;
        logic              neg;
        a = phase[dtg_pkg::PHASE_W-1:dtg_pkg::ADDR_SHIFT];
        priority if (a < EDGE_1)
        begin
            i   = a;
            neg = 1'b0;
        end
        else if (a < EDGE_2)
        begin
            i   = EDGE_2 - a;
            neg = 1'b1;
        end
        else if (a < EDGE_3)
        begin
            i   = a - EDGE_2;
            neg = 1'b1;
        end
        else
        begin
            i   = EDGE_4 - a;
            neg = 1'b0;
        end
        return {neg, i[dtg_pkg::QIDX_W-1:0]};
    endfunction

    assign {neg_a, idx_a} = fold(addr_a);
    assign {neg_b, idx_b} = fold(addr_b);

    always_ff @(posedge clk)
    begin
        data_a_reg <= COS_TABLE[idx_a];
        data_b_reg <= COS_TABLE[idx_b];
        neg_a_reg  <= neg_a;
        neg_b_reg  <= neg_b;
    end

    assign data_a = neg_a_reg ? -data_a_reg : data_a_reg;
    assign data_b = neg_b_reg ? -data_b_reg : data_b_reg;

endmodule

// File: design/dtg_front.sv
module dtg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   command,
    input  logic [31:0]            event_start,
    input  logic [31:0]            event_end,
    input  logic [7:0]             key_char,
    input  logic signed [15:0]     noise_value,
    input  logic                   queue_full,
    output logic                   queue_push,
    output dtg_pkg::job_t          queue_job
);

    logic [31:0]                 sample_index_reg;
    logic [31:0]                 window_begin_reg;
    logic [31:0]                 window_finish_reg;
    logic [7:0]                  window_key_reg;
    logic [dtg_pkg::PHASE_W-1:0] tone_phase_reg  [8];
    logic [dtg_pkg::PHASE_W-1:0] tone_phase_next [8];

    logic              accept;
    logic              is_tick;
    logic              in_window;
    logic              bad_load;
    dtg_pkg::key_map_t key_map;
    dtg_pkg::job_t     job;

    assign accept    = push && !queue_full;
    assign is_tick   = (command == dtg_pkg::CMD_TICK);
    assign bad_load  = (event_start > event_end);
    assign in_window = (sample_index_reg >= window_begin_reg) &&
                       (sample_index_reg < window_finish_reg);
    assign key_map   = dtg_pkg::key_decode(window_key_reg);

    always_comb
    begin
        job = '0;
        if (is_tick)
        begin
            job.row_phase = tone_phase_reg[{1'b0, key_map.row}];
            job.col_phase = tone_phase_reg[{1'b1, key_map.col}];
            job.noise     = noise_value;
            if (in_window && !key_map.known)
            begin
                job.status = dtg_pkg::STATUS_BAD_KEY;
            end
            else
            begin
                job.tone_on = in_window;
                job.mix     = 1'b1;
            end
        end
        else
        begin
            job.status = bad_load ? dtg_pkg::STATUS_BAD_LOAD : dtg_pkg::STATUS_OK;
        end
    end

    // Each accumulator stays below the sample rate, so one conditional subtract wraps it.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            logic [dtg_pkg::PHASE_W:0] sum;
            sum = {1'b0, tone_phase_reg[k]} + {1'b0, dtg_pkg::TONE_FREQ[k]};
            if (sum >= (dtg_pkg::PHASE_W + 1)'(dtg_pkg::PHASE_MODULUS))
                sum = sum - (dtg_pkg::PHASE_W + 1)'(dtg_pkg::PHASE_MODULUS);
            tone_phase_next[k] = sum[dtg_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg  <= '0;
            window_begin_reg  <= '0;
            window_finish_reg <= '0;
            window_key_reg    <= '0;
            for (int k = 0; k < 8; k++)
                tone_phase_reg[k] <= '0;
        end
        else if (accept)
        begin
            if (is_tick)
            begin
                sample_index_reg <= sample_index_reg + 32'd1;
                for (int k = 0; k < 8; k++)
                    tone_phase_reg[k] <= tone_phase_next[k];
            end
            else if (!bad_load)
            begin
                window_begin_reg  <= event_start;
                window_finish_reg <= event_end;
                window_key_reg    <= key_char;
            end
        end
    end

    assign queue_push = accept;
    assign queue_job  = job;

    a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick) |=> (sample_index_reg == $past(sample_index_reg) + 32'd1))
        else $error("sample index did not advance on a tick");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tone_phase_reg[0] < (dtg_pkg::PHASE_W)'(dtg_pkg::PHASE_MODULUS)) &&
        (tone_phase_reg[7] < (dtg_pkg::PHASE_W)'(dtg_pkg::PHASE_MODULUS)))
        else $error("phase accumulator left its range");

endmodule

// File: design/dtg_queue.sv
module dtg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dtg_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output dtg_pkg::job_t head_job
);

    dtg_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("job queue popped while empty");

endmodule

// File: design/dtg_back.sv
module dtg_back #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           noise_enable,
    input  logic [dtg_pkg::WEIGHT_W-1:0]   noise_weight,
    input  logic                           job_valid,
    input  dtg_pkg::job_t                  job,
    output logic                           job_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic signed [15:0]             audio_sample,
    output logic [1:0]                     status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Stage 1: cosine data arrives from the table.
    logic                       s1_valid_reg;
    dtg_pkg::job_t              s1_job_reg;
    logic signed [15:0]         cos_row;
    logic signed [15:0]         cos_col;
    logic signed [16:0]         pair_sum;
    logic signed [16:0]         pair_half;
    logic signed [15:0]         tone;
    logic signed [16:0]         diff;

    // Stage 2: weight times (noise - tone).
    logic                       s2_valid_reg;
    logic signed [15:0]         s2_tone_reg;
    logic signed [16:0]         s2_diff_reg;
    logic                       s2_mix_reg;
    logic [1:0]                 s2_status_reg;
    logic [dtg_pkg::WEIGHT_W-1:0] weight_sat;
    logic signed [17:0]         weight_s;
    logic signed [34:0]         product;

    // Stage 3: add the tone back and scale down.
    logic                       s3_valid_reg;
    logic signed [15:0]         s3_tone_reg;
    logic signed [34:0]         s3_prod_reg;
    logic                       s3_mix_reg;
    logic [1:0]                 s3_status_reg;
    logic signed [34:0]         acc;
    logic signed [34:0]         acc_biased;
    logic signed [34:0]         acc_scaled;
    logic signed [15:0]         final_sample;

    // Result queue.
    logic signed [15:0]         res_audio_reg  [DEPTH];
    logic [1:0]                 res_status_reg [DEPTH];
    logic [PTR_W-1:0]           res_wr_ptr_reg;
    logic [PTR_W-1:0]           res_rd_ptr_reg;
    logic [CNT_W-1:0]           res_count_reg;
    logic [CNT_W-1:0]           res_count_next;
    logic                       res_pop;
    logic [1:0]                 in_flight;
    logic                       credit_ok;

    // A job is issued only if the result queue has room for it and everything ahead of it.
    assign in_flight = 2'(s1_valid_reg) + 2'(s2_valid_reg) + 2'(s3_valid_reg);
    assign credit_ok = ((CNT_W + 1)'(res_count_reg) + (CNT_W + 1)'(in_flight))
                       < (CNT_W + 1)'(DEPTH);
    assign job_pop   = job_valid && credit_ok;

    dtg_cos_rom u_cos_rom (
        .clk    (clk),
        .addr_a (job.row_phase),
        .addr_b (job.col_phase),
        .data_a (cos_row),
        .data_b (cos_col)
    );

    // Halving truncates toward zero.
    always_comb
    begin
        pair_sum  = {cos_row[15], cos_row} + {cos_col[15], cos_col};
        pair_half = pair_sum[16] ? ((pair_sum + 17'sd1) >>> 1) : (pair_sum >>> 1);
        tone      = s1_job_reg.tone_on ? pair_half[15:0] : 16'sd0;
        diff      = {s1_job_reg.noise[15], s1_job_reg.noise} - {tone[15], tone};
    end

    // The mix w*noise + (1-w)*tone is rewritten as tone + w*(noise - tone).
    assign weight_sat = (noise_weight > dtg_pkg::WEIGHT_ONE) ? dtg_pkg::WEIGHT_ONE
                                                             : noise_weight;
    assign weight_s   = $signed({1'b0, weight_sat});
    assign product    = weight_s * s2_diff_reg;

    always_comb
    begin
        acc          = $signed({{3{s3_tone_reg[15]}}, s3_tone_reg, 16'd0}) + s3_prod_reg;
        acc_biased   = acc[34] ? (acc + 35'sd65535) : acc;
        acc_scaled   = acc_biased >>> 16;
        final_sample = s3_mix_reg ? acc_scaled[15:0] : s3_tone_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= job_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_job_reg    <= job;
        s2_tone_reg   <= tone;
        s2_diff_reg   <= diff;
        s2_mix_reg    <= s1_job_reg.mix && noise_enable;
        s2_status_reg <= s1_job_reg.status;
        s3_tone_reg   <= s2_tone_reg;
        s3_prod_reg   <= product;
        s3_mix_reg    <= s2_mix_reg;
        s3_status_reg <= s2_status_reg;
    end

    assign empty   = (res_count_reg == '0);
    assign res_pop = pop && !empty;

    always_comb
    begin
        res_count_next = res_count_reg;
        if (s3_valid_reg && !res_pop)
            res_count_next = res_count_reg + CNT_W'(1);
        else if (res_pop && !s3_valid_reg)
            res_count_next = res_count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (s3_valid_reg)
                res_wr_ptr_reg <= (res_wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                  : res_wr_ptr_reg + PTR_W'(1);
            if (res_pop)
                res_rd_ptr_reg <= (res_rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                  : res_rd_ptr_reg + PTR_W'(1);
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            res_audio_reg[res_wr_ptr_reg]  <= final_sample;
            res_status_reg[res_wr_ptr_reg] <= s3_status_reg;
        end
    end

    assign audio_sample = res_audio_reg[res_rd_ptr_reg];
    assign status       = res_status_reg[res_rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ((res_count_reg < CNT_W'(DEPTH)) || res_pop))
        else $error("result queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(res_count_reg) + (CNT_W + 1)'(in_flight)) <= (CNT_W + 1)'(DEPTH))
        else $error("results in flight exceed result queue room");

endmodule

// File: design/dtmf_tone_generator_core.sv
// Channel   Direction  Handshake            Payload
// input     in         push / full          command, event_start, event_end, key_char,
//                                           noise_value
// result    out        pop / empty          audio_sample, status
// config    in         cfg_write (no wait)  cfg_index, cfg_data
//
// One request is taken per cycle while full is low; each gives one result after it
// passes the job queue, the cosine table read, the weight multiply and the final
// scaling, and results then leave at one per cycle while pop is high and empty is low.
// The result queue of DEPTH entries sets how long pop may stall before full rises.
// Reset is asynchronous and active low; it clears the sample index, window and phases,
// disables noise and sets the noise weight to one half.
module dtmf_tone_generator_core #(
    parameter int unsigned DEPTH = 8  // result queue entries, 2 or more
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                command,
    input  logic [31:0]                         event_start,
    input  logic [31:0]                         event_end,
    input  logic [7:0]                          key_char,
    input  logic signed [15:0]                  noise_value,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [15:0]                  audio_sample,
    output logic [1:0]                          status,
    input  logic                                cfg_write,
    input  logic [dtg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dtg_pkg::WEIGHT_W-1:0]        cfg_data
);

    logic                          noise_enable_reg;
    logic [dtg_pkg::WEIGHT_W-1:0]  noise_weight_reg;

    logic          queue_full;
    logic          queue_push;
    dtg_pkg::job_t queue_in_job;
    logic          queue_valid;
    logic          queue_pop;
    dtg_pkg::job_t queue_head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_enable_reg <= 1'b0;
            noise_weight_reg <= dtg_pkg::WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dtg_pkg::REG_NOISE_ENABLE: noise_enable_reg <= cfg_data[0];
                dtg_pkg::REG_NOISE_WEIGHT: noise_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dtg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .command      (command),
        .event_start  (event_start),
        .event_end    (event_end),
        .key_char     (key_char),
        .noise_value  (noise_value),
        .queue_full   (queue_full),
        .queue_push   (queue_push),
        .queue_job    (queue_in_job)
    );

    dtg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .push_job (queue_in_job),
        .pop      (queue_pop),
        .full     (queue_full),
        .valid    (queue_valid),
        .head_job (queue_head_job)
    );

    dtg_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .noise_enable (noise_enable_reg),
        .noise_weight (noise_weight_reg),
        .job_valid    (queue_valid),
        .job          (queue_head_job),
        .job_pop      (queue_pop),
        .pop          (pop),
        .empty        (empty),
        .audio_sample (audio_sample),
        .status       (status)
    );

    assign full = queue_full;

endmodule

// File: dv/tb_dtmf_tone_generator_core.sv
`timescale 1ns / 1ps

module tb_dtmf_tone_generator_core;

    localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
    localparam longint          UNIT_FIX    = 64'sd1073741824;
    localparam logic [dtg_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int TONE_STEP [8] = '{697, 770, 852, 941, 1209, 1336, 1477, 1633};
    localparam logic [7:0] KEYPAD [16] = '{
        "1", "2", "3", "A", "4", "5", "6", "B",
        "7", "8", "9", "C", "*", "0", "#", "D"
    };

    typedef struct packed {
        logic               cmd;
        logic [31:0]        start_at;
        logic [31:0]        end_at;
        logic [7:0]         key;
        logic signed [15:0] noise;
    } request_t;

    typedef struct packed {
        logic signed [15:0] audio;
        logic [1:0]         status;
    } tone_out_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              push = 1'b0;
    logic                              full;
    logic                              command = dtg_pkg::CMD_TICK;
    logic [31:0]                       event_start = '0;
    logic [31:0]                       event_end = '0;
    logic [7:0]                        key_char = '0;
    logic signed [15:0]                noise_value = '0;
    logic                              empty;
    logic                              pop = 1'b0;
    logic signed [15:0]                audio_sample;
    logic [1:0]                        status;
    logic                              cfg_write = 1'b0;
    logic [dtg_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [dtg_pkg::WEIGHT_W-1:0]      cfg_data = '0;

    request_t  pending_requests [$];
    tone_out_t expected_samples [$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      req_taken = 1'b0;
    logic [31:0] ticks_issued = '0;

    // Predictor state, mirroring the block's registers.
    int          cos_q15 [dtg_pkg::COS_TABLE_DEPTH];
    logic [31:0] sample_idx = '0;
    logic [31:0] win_begin = '0;
    logic [31:0] win_finish = '0;
    logic [7:0]  win_key = '0;
    logic [12:0] phase_acc [8] = '{default: '0};
    logic        noise_on = 1'b0;
    logic [16:0] noise_wt = 17'd32768;

    dtmf_tone_generator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .event_start  (event_start),
        .event_end    (event_end),
        .key_char     (key_char),
        .noise_value  (noise_value),
        .empty        (empty),
        .pop          (pop),
        .audio_sample (audio_sample),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cosine over a quarter wave in Q15, from a truncating Q30 Taylor series.
    function automatic int quarter_wave(input longint unsigned n);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = HALF_PI_FIX * n / dtg_pkg::COS_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = 64'd1073741824;
        sum  = UNIT_FIX;
        for (int k = 1; k <= 7; k++)
        begin
            term = term * x2 / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > UNIT_FIX)
            sum = UNIT_FIX;
        return int'((sum * 32767 + UNIT_FIX / 2) / UNIT_FIX);
    endfunction

    function automatic bit key_position(input logic [7:0] key, output int row, output int col);
        row = 0;
        col = 0;
        for (int k = 0; k < 16; k++)
        begin
            if (KEYPAD[k] == key)
            begin
                row = k / 4;
                col = k % 4;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic synth_step(input request_t r, output tone_out_t res);
        int     row;
        int     col;
        int     tone;
        longint w;
        longint acc;
        logic   mix;
        tone = 0;
        mix = 1'b1;
        res.status = dtg_pkg::STATUS_OK;
        if (r.cmd == dtg_pkg::CMD_LOAD)
        begin
            if (r.start_at > r.end_at)
                res.status = dtg_pkg::STATUS_BAD_LOAD;
            else
            begin
                win_begin = r.start_at;
                win_finish = r.end_at;
                win_key = r.key;
            end
        end
        else
        begin
            if (sample_idx >= win_begin && sample_idx < win_finish)
            begin
                if (key_position(win_key, row, col))
                    tone = (cos_q15[int'(phase_acc[row]) * dtg_pkg::COS_TABLE_DEPTH
                                    / dtg_pkg::PHASE_MODULUS]
                          + cos_q15[int'(phase_acc[4 + col]) * dtg_pkg::COS_TABLE_DEPTH
                                    / dtg_pkg::PHASE_MODULUS]) / 2;
                else
                begin
                    res.status = dtg_pkg::STATUS_BAD_KEY;
                    mix = 1'b0;
                end
            end
            if (mix && noise_on)
            begin
                w = (noise_wt > 17'd65536) ? 65536 : longint'(noise_wt);
                acc = w * longint'(r.noise) + (65536 - w) * longint'(tone);
                tone = int'(acc / 65536);
            end
            for (int k = 0; k < 8; k++)
                phase_acc[k] = 13'((int'(phase_acc[k]) + TONE_STEP[k])
                                   % dtg_pkg::PHASE_MODULUS);
            sample_idx = sample_idx + 1;
        end
        res.audio = 16'(tone);
    endtask

    always @(negedge clk)
    begin
        request_t nxt_req;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || req_taken)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt_req = pending_requests.pop_front();
                push <= 1'b1;
                command <= nxt_req.cmd;
                event_start <= nxt_req.start_at;
                event_end <= nxt_req.end_at;
                key_char <= nxt_req.key;
                noise_value <= nxt_req.noise;
            end
            else
                push <= 1'b0;
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        request_t  req;
        tone_out_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected sample audio=%0d status=%0d",
                                 $realtime, audio_sample, status);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (audio_sample !== want.audio || status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch audio exp=%0d got=%0d status exp=%0d got=%0d",
                                     $realtime, want.audio, audio_sample, want.status, status);
                    end
                end
            end
            if (push && !full)
            begin
                req_taken = 1'b1;
                req = '{command, event_start, event_end, key_char, noise_value};
                synth_step(req, want);
                expected_samples.push_back(want);
            end
        end
    end

    task automatic queue_load(input logic [31:0] s, input logic [31:0] e, input logic [7:0] key);
        pending_requests.push_back(request_t'{dtg_pkg::CMD_LOAD, s, e, key, 16'($urandom)});
    endtask

    task automatic queue_tick(input logic signed [15:0] noise);
        pending_requests.push_back(request_t'{dtg_pkg::CMD_TICK, $urandom, $urandom,
                                              8'($urandom), noise});
        ticks_issued = ticks_issued + 1;
    endtask

    function automatic logic signed [15:0] pick_noise();
        unique case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [dtg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dtg_pkg::WEIGHT_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == dtg_pkg::REG_NOISE_ENABLE)
            noise_on = data[0];
        else if (idx == dtg_pkg::REG_NOISE_WEIGHT)
            noise_wt = data;
    endtask

    // Waits until every request has been sent and has come out the far side.
    task automatic drain();
        while (pending_requests.size() != 0 || push || expected_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic fill_random(input int count);
        int          made;
        int          n;
        logic [31:0] s;
        logic [7:0]  key;
        made = 0;
        while (made < count)
        begin
            n = $urandom_range(99);
            if (n < 75)
            begin
                // A well-formed event starting near the current sample index.
                s = ticks_issued + $urandom_range(0, 6);
                key = ($urandom_range(9) == 0) ? 8'($urandom) : KEYPAD[$urandom_range(15)];
                queue_load(s, s + $urandom_range(0, 40), key);
                n = $urandom_range(1, 48);
                made += n + 1;
                repeat (n) queue_tick(pick_noise());
            end
            else if (n < 88)
            begin
                queue_load($urandom, $urandom, 8'($urandom));
                made++;
            end
            else
            begin
                queue_tick(pick_noise());
                made++;
            end
        end
    endtask

    initial
    begin
        for (int a = 0; a < dtg_pkg::COS_TABLE_DEPTH; a++)
        begin
            int four;
            int quad;
            int r;
            int v;
            four = a * 4;
            quad = four / dtg_pkg::COS_TABLE_DEPTH;
            r = four % dtg_pkg::COS_TABLE_DEPTH;
            v = quarter_wave((quad % 2 == 1) ? dtg_pkg::COS_TABLE_DEPTH - r : r);
            cos_q15[a] = (quad == 1 || quad == 2) ? -v : v;
        end
        send_idle_pct = 6;
        recv_idle_pct = 45;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Pure tone: empty window, rejected load, empty event, unknown keys in and out
        // of the window, a window spanning every index but the last, a one-sample event.
        queue_tick(-16'sd32768);
        queue_load(32'hFFFF_FFFF, 32'h0, "5");
        queue_load(ticks_issued, ticks_issued, "1");
        queue_tick(16'sd32767);
        queue_load(ticks_issued, ticks_issued + 2, "X");
        queue_tick(16'sd0);
        queue_tick(16'sd0);
        queue_load(32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'hFF);
        queue_tick(16'sd1);
        queue_load(32'h0, 32'hFFFF_FFFF, "#");
        queue_tick(-16'sd1);
        queue_tick(16'sd100);
        queue_load(ticks_issued, ticks_issued + 1, "D");
        queue_tick(16'sd5);
        queue_tick(16'sd5);
        drain();

        // Unmapped register, then a weight above one that must saturate.
        write_reg(REG_UNMAPPED, '1);
        write_reg(dtg_pkg::REG_NOISE_WEIGHT, 17'h1FFFF);
        write_reg(dtg_pkg::REG_NOISE_ENABLE, 1'b1);
        queue_load(ticks_issued, ticks_issued + 3, "C");
        queue_tick(16'sd32767);
        queue_tick(-16'sd32768);
        queue_load(ticks_issued, ticks_issued + 1, 8'h80);
        queue_tick(16'sd1234);
        queue_tick(-16'sd1);
        drain();

        for (int seg = 0; seg < 6; seg++)
        begin
            unique case (seg)
                0: write_reg(dtg_pkg::REG_NOISE_ENABLE, 1'b0);
                1:
                begin
                    write_reg(dtg_pkg::REG_NOISE_ENABLE, 1'b1);
                    write_reg(dtg_pkg::REG_NOISE_WEIGHT, 17'd0);
                end
                2: write_reg(dtg_pkg::REG_NOISE_WEIGHT, 17'd65536);
                3: write_reg(dtg_pkg::REG_NOISE_WEIGHT, 17'($urandom_range(0, 65536)));
                4: write_reg(dtg_pkg::REG_NOISE_WEIGHT, 17'($urandom));
                default:
                begin
                    write_reg(dtg_pkg::REG_NOISE_ENABLE, 1'b0);
                    write_reg(dtg_pkg::REG_NOISE_WEIGHT, 17'($urandom));
                end
            endcase
            send_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 45 : 0;
            recv_idle_pct = (seg < 2) ? 45 : (seg < 4) ? 6 : 0;
            fill_random(265);
            drain();
        end

        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
